/* rtl/core/scd_pkg.sv */
package scd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_FINISH = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [2:0] POL_FCFS  = 3'd0;
    localparam logic [2:0] POL_PRIO  = 3'd1;
    localparam logic [2:0] POL_PPRIO = 3'd2;
    localparam logic [2:0] POL_SRTF  = 3'd3;
    localparam logic [2:0] POL_RR    = 3'd4;
    localparam logic [2:0] POL_SJF   = 3'd5;

    typedef enum logic [1:0] {
        SRC_SLOT = 2'd0,
        SRC_E0   = 2'd1,
        SRC_E1   = 2'd2
    } t_src;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] prio;
        logic [31:0] arrival;
        logic [31:0] requeue;
        logic        started;
        logic [31:0] start;
        logic [31:0] total;
        logic [31:0] remain;
        logic [31:0] order;
    } t_job;

    typedef struct packed {
        logic in_rdy;
        logic load;
        logic prep;
        logic scan_rd;
        logic ce0;
        logic ce1;
        logic commit;
        logic ins0;
        logic ins1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic disp;
        logic scan_last;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] sort_key(t_job j, logic [2:0] pol);
        logic [31:0] k;
        case (pol)
            POL_PRIO, POL_PPRIO: k = {16'd0, j.prio};
            POL_SRTF:            k = j.remain;
            POL_RR:              k = j.requeue;
            POL_SJF:             k = j.total;
            default:             k = j.arrival;
        endcase
        return k;
    endfunction

    function automatic logic comes_first(t_job a, t_job b, logic [2:0] pol);
        logic [31:0] ka;
        logic [31:0] kb;
        logic [31:0] d;
        logic        r;
        ka = sort_key(a, pol);
        kb = sort_key(b, pol);
        d  = a.order - b.order;
        if (ka != kb) begin
            r = ka < kb;
        end else if (a.arrival != b.arrival) begin
            r = a.arrival < b.arrival;
        end else begin
            r = d[31];
        end
        return r;
    endfunction

    // running job leaves the core: charge elapsed slice, restamp order
    function automatic t_job take_off(t_job j, logic [31:0] now, logic [31:0] slice,
                                      logic [31:0] order);
        t_job        o;
        logic [31:0] el;
        o  = j;
        el = now - slice;
        if (j.started && j.start == now) begin
            o.started = 1'b0;
        end
        o.remain = (j.remain > el) ? j.remain - el : 32'd0;
        o.order  = order;
        return o;
    endfunction

endpackage

/* rtl/core/scd_if.sv */
interface scd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] job_id;
    logic [31:0] now;
    logic [31:0] run_length;
    logic [15:0] prio;
    modport source (output valid, op, job_id, now, run_length, prio, input ready);
    modport sink   (input valid, op, job_id, now, run_length, prio, output ready);
endinterface

interface scd_out_if;
    logic        valid;
    logic        ready;
    logic        core_busy;
    logic [15:0] running_id;
    logic        arrival_dispatched;
    logic        wrong_job;
    logic        idle_error;
    logic        queue_full;
    logic [63:0] sum_turnaround;
    logic [63:0] sum_response;
    logic [63:0] sum_wait;
    logic [31:0] jobs_done;
    modport source (output valid, core_busy, running_id, arrival_dispatched, wrong_job,
                    idle_error, queue_full, sum_turnaround, sum_response, sum_wait,
                    jobs_done, input ready);
    modport sink   (input valid, core_busy, running_id, arrival_dispatched, wrong_job,
                    idle_error, queue_full, sum_turnaround, sum_response, sum_wait,
                    jobs_done, output ready);
endinterface

interface scd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] policy;
    modport source (output valid, policy, input ready);
    modport sink   (input valid, policy, output ready);
endinterface

/* rtl/core/scd_datapath.sv */
module scd_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scd_in_if.sink          i_job,
    scd_out_if.source       o_res,
    scd_cfg_if.sink         i_cfg,
    input  scd_pkg::t_cmd   i_cmd,
    output scd_pkg::t_sts   o_sts
);

    logic [2:0]                   r_policy;
    scd_pkg::t_op                 r_op;
    logic [15:0]                  r_id;
    logic [31:0]                  r_now;
    logic [31:0]                  r_len;
    logic [15:0]                  r_prio;

    logic [scd_pkg::QUEUE_DEPTH-1:0] r_valid;
    scd_pkg::t_job                m_slot [scd_pkg::QUEUE_DEPTH];
    scd_pkg::t_job                r_rdata;
    logic                         r_rd_tag;
    logic [scd_pkg::IDX_W-1:0]    r_rd_idx;
    logic [scd_pkg::IDX_W-1:0]    r_idx;

    scd_pkg::t_job                r_run;
    logic                         r_run_v;
    logic [31:0]                  r_slice;
    logic [31:0]                  r_ic;
    logic [63:0]                  r_sum_t;
    logic [63:0]                  r_sum_r;
    logic [63:0]                  r_sum_w;
    logic [31:0]                  r_done;

    scd_pkg::t_job                r_e0;
    scd_pkg::t_job                r_e1;
    logic                         r_e0_v;
    logic                         r_e1_v;
    logic                         r_disp;
    scd_pkg::t_job                r_best;
    logic                         r_best_v;
    scd_pkg::t_src                r_best_src;
    logic [scd_pkg::IDX_W-1:0]    r_best_idx;

    logic r_full, r_idle, r_wrong, r_won;

    logic        r_out_v;
    logic        r_o_busy;
    logic [15:0] r_o_id;
    logic        r_o_won, r_o_wrong, r_o_idle, r_o_full;
    logic [63:0] r_o_st, r_o_sr, r_o_sw;
    logic [31:0] r_o_done;

    logic [scd_pkg::IDX_W-1:0] w_free_idx;
    logic                      w_any_free;
    logic                      w_ins0, w_ins1, w_we;
    scd_pkg::t_job             w_new, w_wdata, w_win, w_exp;
    logic [31:0]               w_turn, w_resp;
    logic [63:0]               w_wait;
    logic                      w_take_slot, w_take_e0, w_take_e1;

    assign i_job.ready = i_cmd.in_rdy;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        w_free_idx = '0;
        w_any_free = 1'b0;
        for (int k = scd_pkg::QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free_idx = scd_pkg::IDX_W'(k);
                w_any_free = 1'b1;
            end
        end
    end

    always_comb begin
        w_new         = '0;
        w_new.id      = r_id;
        w_new.prio    = r_prio;
        w_new.arrival = r_now;
        w_new.requeue = r_now;
        w_new.total   = r_len;
        w_new.remain  = r_len;
        w_new.order   = r_ic;
    end

    // expiring job: charged, restamped and requeued at the current time
    always_comb begin
        w_exp         = scd_pkg::take_off(r_run, r_now, r_slice, r_ic);
        w_exp.requeue = r_now;
    end

    assign w_turn = r_now - r_run.arrival;
    assign w_resp = r_run.start - r_run.arrival;
    assign w_wait = {32'd0, w_turn} - {32'd0, r_run.total};

    assign w_take_slot = r_rd_tag &&
        (!r_best_v || scd_pkg::comes_first(r_rdata, r_best, r_policy));
    assign w_take_e0 = i_cmd.ce0 && r_e0_v &&
        (!r_best_v || scd_pkg::comes_first(r_e0, r_best, r_policy));
    assign w_take_e1 = i_cmd.ce1 && r_e1_v &&
        (!r_best_v || scd_pkg::comes_first(r_e1, r_best, r_policy));

    // losing extras go back into the first free slot, one per cycle
    assign w_ins0 = i_cmd.ins0 && r_e0_v && w_any_free &&
                    !(r_best_v && r_best_src == scd_pkg::SRC_E0);
    assign w_ins1 = i_cmd.ins1 && r_e1_v && w_any_free &&
                    !(r_best_v && r_best_src == scd_pkg::SRC_E1);
    assign w_we    = w_ins0 || w_ins1;
    assign w_wdata = w_ins0 ? r_e0 : r_e1;

    always_comb begin
        w_win = r_best;
        if (!r_best.started) begin
            w_win.started = 1'b1;
            w_win.start   = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_slot[w_free_idx] <= w_wdata;
        end
        r_rdata  <= m_slot[r_idx];
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= scd_pkg::POL_FCFS;
            r_valid  <= '0;
            r_rd_tag <= 1'b0;
            r_idx    <= '0;
            r_run_v  <= 1'b0;
            r_slice  <= '0;
            r_ic     <= '0;
            r_sum_t  <= '0;
            r_sum_r  <= '0;
            r_sum_w  <= '0;
            r_done   <= '0;
            r_e0_v   <= 1'b0;
            r_e1_v   <= 1'b0;
            r_disp   <= 1'b0;
            r_best_v <= 1'b0;
            r_full   <= 1'b0;
            r_idle   <= 1'b0;
            r_wrong  <= 1'b0;
            r_won    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_policy <= i_cfg.policy;
            end

            if (i_cmd.load) begin
                r_op   <= scd_pkg::t_op'(i_job.op);
                r_id   <= i_job.job_id;
                r_now  <= i_job.now;
                r_len  <= i_job.run_length;
                r_prio <= i_job.prio;
            end

            if (i_cmd.prep) begin
                r_full   <= 1'b0;
                r_idle   <= 1'b0;
                r_wrong  <= 1'b0;
                r_won    <= 1'b0;
                r_e0_v   <= 1'b0;
                r_e1_v   <= 1'b0;
                r_disp   <= 1'b0;
                r_best_v <= 1'b0;
                r_idx    <= '0;
                case (r_op)
                    scd_pkg::OP_ARRIVE: begin
                        if (r_run_v && !w_any_free) begin
                            r_full <= 1'b1;
                        end else begin
                            r_e0   <= w_new;
                            r_e0_v <= 1'b1;
                            if (!r_run_v) begin
                                r_ic   <= r_ic + 32'd1;
                                r_disp <= 1'b1;
                            end else if (r_policy == scd_pkg::POL_PPRIO ||
                                         r_policy == scd_pkg::POL_SRTF) begin
                                r_e1   <= scd_pkg::take_off(r_run, r_now, r_slice,
                                                            r_ic + 32'd1);
                                r_e1_v <= 1'b1;
                                r_ic   <= r_ic + 32'd2;
                                r_disp <= 1'b1;
                            end else begin
                                r_ic <= r_ic + 32'd1;
                            end
                        end
                    end
                    scd_pkg::OP_FINISH: begin
                        if (!r_run_v) begin
                            r_idle <= 1'b1;
                        end else begin
                            r_wrong <= r_run.id != r_id;
                            r_sum_t <= r_sum_t + {32'd0, w_turn};
                            r_sum_r <= r_sum_r + {32'd0, w_resp};
                            r_sum_w <= r_sum_w + w_wait;
                            r_done  <= r_done + 32'd1;
                            r_disp  <= 1'b1;
                        end
                    end
                    scd_pkg::OP_EXPIRE: begin
                        if (!r_run_v) begin
                            r_idle <= 1'b1;
                        end else begin
                            r_e0   <= w_exp;
                            r_e0_v <= 1'b1;
                            r_ic   <= r_ic + 32'd1;
                            r_disp <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + scd_pkg::IDX_W'(1);
            end
            r_rd_tag <= i_cmd.scan_rd && r_valid[r_idx];

            if (w_take_slot) begin
                r_best     <= r_rdata;
                r_best_v   <= 1'b1;
                r_best_src <= scd_pkg::SRC_SLOT;
                r_best_idx <= r_rd_idx;
            end else if (w_take_e0) begin
                r_best     <= r_e0;
                r_best_v   <= 1'b1;
                r_best_src <= scd_pkg::SRC_E0;
            end else if (w_take_e1) begin
                r_best     <= r_e1;
                r_best_v   <= 1'b1;
                r_best_src <= scd_pkg::SRC_E1;
            end

            if (i_cmd.commit && r_disp) begin
                r_run_v <= r_best_v;
                if (r_best_v) begin
                    r_run   <= w_win;
                    r_slice <= r_now;
                    r_won   <= (r_op == scd_pkg::OP_ARRIVE) &&
                               (r_best_src == scd_pkg::SRC_E0);
                    if (r_best_src == scd_pkg::SRC_SLOT) begin
                        r_valid[r_best_idx] <= 1'b0;
                    end
                end
            end

            if (w_we) begin
                r_valid[w_free_idx] <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_v   <= 1'b1;
                r_o_busy  <= r_run_v;
                r_o_id    <= r_run_v ? r_run.id : 16'd0;
                r_o_won   <= r_won;
                r_o_wrong <= r_wrong;
                r_o_idle  <= r_idle;
                r_o_full  <= r_full;
                r_o_st    <= r_sum_t;
                r_o_sr    <= r_sum_r;
                r_o_sw    <= r_sum_w;
                r_o_done  <= r_done;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_res.valid              = r_out_v;
    assign o_res.core_busy          = r_o_busy;
    assign o_res.running_id         = r_o_id;
    assign o_res.arrival_dispatched = r_o_won;
    assign o_res.wrong_job          = r_o_wrong;
    assign o_res.idle_error         = r_o_idle;
    assign o_res.queue_full         = r_o_full;
    assign o_res.sum_turnaround     = r_o_st;
    assign o_res.sum_response       = r_o_sr;
    assign o_res.sum_wait           = r_o_sw;
    assign o_res.jobs_done          = r_o_done;

    assign o_sts.in_valid  = i_job.valid;
    assign o_sts.disp      = r_disp;
    assign o_sts.scan_last = r_idx == scd_pkg::IDX_W'(scd_pkg::QUEUE_DEPTH - 1);
    assign o_sts.out_free  = !r_out_v || o_res.ready;

endmodule

/* rtl/core/scd_ctrl.sv */
module scd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scd_pkg::t_sts   i_sts,
    output scd_pkg::t_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PREP   = 10'b00_0000_0010,
        S_SCAN   = 10'b00_0000_0100,
        S_DRAIN  = 10'b00_0000_1000,
        S_CE0    = 10'b00_0001_0000,
        S_CE1    = 10'b00_0010_0000,
        S_COMMIT = 10'b00_0100_0000,
        S_INS0   = 10'b00_1000_0000,
        S_INS1   = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (!i_sts.disp) begin
                    n_state = S_INS0;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_CE0;
            end
            S_CE0: begin
                o_cmd.ce0 = 1'b1;
                n_state   = S_CE1;
            end
            S_CE1: begin
                o_cmd.ce1 = 1'b1;
                n_state   = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_INS0;
            end
            S_INS0: begin
                o_cmd.ins0 = 1'b1;
                n_state    = S_INS1;
            end
            S_INS1: begin
                o_cmd.ins1 = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/single_core_job_scheduler_top.sv */
// Channel  | Dir | Handshake    | Payload
// i_job    | in  | valid/ready  | op, job_id, now, run_length, prio
// o_res    | out | valid/ready  | core_busy, running_id, flags, sums, jobs_done
// i_cfg    | in  | valid/ready  | policy (ready always high)
//
// One request at a time. A dispatching event scans the queue RAM one slot per
// cycle, then compares the extras and commits; other events skip the scan,
// compare and commit steps. Reset (i_rst_n low, synchronous) empties the
// queue, idles the core and clears the sums. A stalled o_res holds only the
// final step; the next request is taken once the result register is loaded.
module single_core_job_scheduler_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scd_in_if.sink     i_job,
    scd_out_if.source  o_res,
    scd_cfg_if.sink    i_cfg
);

    // controller sequences the event, datapath holds queue, core and sums
    scd_pkg::t_cmd w_cmd;
    scd_pkg::t_sts w_sts;

    scd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    scd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (i_job),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

/* dv/scd_tb_if.sv */
`timescale 1ns / 100ps

// Interfaces live with the RTL (scd_if.sv); this file only carries the
// request and result records used by the stimulus table, driver and checker.
package scd_tb_pkg;

    typedef struct {
        scd_pkg::t_op op;
        logic [15:0]  job_id;
        logic [31:0]  now;
        logic [31:0]  run_length;
        logic [15:0]  prio;
    } t_req;

    typedef struct {
        logic        core_busy;
        logic [15:0] running_id;
        logic        arrival_dispatched;
        logic        wrong_job;
        logic        idle_error;
        logic        queue_full;
        logic [63:0] sum_turnaround;
        logic [63:0] sum_response;
        logic [63:0] sum_wait;
        logic [31:0] jobs_done;
    } t_res;
endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;

    scd_in_if  job_ch ();
    scd_out_if res_ch ();
    scd_cfg_if cfg_ch ();

    single_core_job_scheduler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Scheduler shadow state
    // ---------------------------------------------------------------
    logic [2:0]     sh_policy;
    logic           sh_valid [scd_pkg::QUEUE_DEPTH];
    scd_pkg::t_job  sh_slot  [scd_pkg::QUEUE_DEPTH];
    logic [31:0]    sh_insert;
    logic           sh_run_on;
    scd_pkg::t_job  sh_run;
    logic [31:0]    sh_slice;
    logic [63:0]    sh_turn, sh_resp, sh_wait;
    logic [31:0]    sh_done;

    scd_tb_pkg::t_res expected_results [$];
    int   errors;
    int   accepted_reqs;
    int   accepted_results;
    bit   drv_done;

    function automatic logic [31:0] job_key(scd_pkg::t_job j);
        case (sh_policy)
            scd_pkg::POL_PRIO, scd_pkg::POL_PPRIO: return {16'd0, j.prio};
            scd_pkg::POL_SRTF:                     return j.remain;
            scd_pkg::POL_RR:                       return j.requeue;
            scd_pkg::POL_SJF:                      return j.total;
            default:                               return j.arrival;
        endcase
    endfunction

    function automatic bit ahead_of(scd_pkg::t_job a, scd_pkg::t_job b);
        logic [31:0] ka, kb, d;
        ka = job_key(a);
        kb = job_key(b);
        d  = a.order - b.order;
        if (ka != kb) return ka < kb;
        if (a.arrival != b.arrival) return a.arrival < b.arrival;
        return d[31];
    endfunction

    function automatic void park_job(scd_pkg::t_job j);
        for (int i = 0; i < scd_pkg::QUEUE_DEPTH; i++) begin
            if (!sh_valid[i]) begin
                sh_valid[i] = 1'b1;
                sh_slot[i]  = j;
                return;
            end
        end
    endfunction

    function automatic int queued_jobs();
        int n;
        n = 0;
        for (int i = 0; i < scd_pkg::QUEUE_DEPTH; i++) n += sh_valid[i];
        return n;
    endfunction

    // picks best of queue plus candidates; returns winning candidate or -1
    function automatic int pick_next(scd_pkg::t_job cand [2], int ncand, logic [31:0] now);
        scd_pkg::t_job best;
        bit   have;
        int   from;
        have = 0;
        from = -1;
        for (int i = 0; i < scd_pkg::QUEUE_DEPTH; i++) begin
            if (sh_valid[i] && (!have || ahead_of(sh_slot[i], best))) begin
                best = sh_slot[i];
                have = 1;
                from = i;
            end
        end
        for (int k = 0; k < ncand; k++) begin
            if (!have || ahead_of(cand[k], best)) begin
                best = cand[k];
                have = 1;
                from = scd_pkg::QUEUE_DEPTH + k;
            end
        end
        if (!have) begin
            sh_run_on = 1'b0;
            return -1;
        end
        if (from < scd_pkg::QUEUE_DEPTH) sh_valid[from] = 1'b0;
        for (int k = 0; k < ncand; k++)
            if (from != scd_pkg::QUEUE_DEPTH + k) park_job(cand[k]);
        if (!best.started) begin
            best.started = 1'b1;
            best.start   = now;
        end
        sh_run    = best;
        sh_run_on = 1'b1;
        sh_slice  = now;
        return (from >= scd_pkg::QUEUE_DEPTH) ? from - scd_pkg::QUEUE_DEPTH : -1;
    endfunction

    function automatic void preempt_running(logic [31:0] now);
        logic [31:0] el;
        el = now - sh_slice;
        if (sh_run.started && sh_run.start == now) sh_run.started = 1'b0;
        sh_run.remain = (sh_run.remain > el) ? sh_run.remain - el : 32'd0;
        sh_run.order  = sh_insert;
        sh_insert++;
    endfunction

    function automatic scd_tb_pkg::t_res schedule_event(scd_tb_pkg::t_req r);
        scd_tb_pkg::t_res o;
        scd_pkg::t_job    cand [2];
        logic [31:0]      turn;
        o = '{default: '0};
        case (r.op)
            scd_pkg::OP_ARRIVE: begin
                if (sh_run_on && queued_jobs() >= scd_pkg::QUEUE_DEPTH) begin
                    o.queue_full = 1'b1;
                end else begin
                    cand[0] = '0;
                    cand[0].id      = r.job_id;
                    cand[0].prio    = r.prio;
                    cand[0].arrival = r.now;
                    cand[0].requeue = r.now;
                    cand[0].total   = r.run_length;
                    cand[0].remain  = r.run_length;
                    cand[0].order   = sh_insert;
                    sh_insert++;
                    if (!sh_run_on) begin
                        o.arrival_dispatched = pick_next(cand, 1, r.now) == 0;
                    end else if (sh_policy == scd_pkg::POL_PPRIO ||
                                 sh_policy == scd_pkg::POL_SRTF) begin
                        preempt_running(r.now);
                        cand[1]   = sh_run;
                        sh_run_on = 1'b0;
                        o.arrival_dispatched = pick_next(cand, 2, r.now) == 0;
                    end else begin
                        park_job(cand[0]);
                    end
                end
            end
            scd_pkg::OP_FINISH: begin
                if (!sh_run_on) begin
                    o.idle_error = 1'b1;
                end else begin
                    turn = r.now - sh_run.arrival;
                    o.wrong_job = sh_run.id != r.job_id;
                    sh_turn += 64'(turn);
                    sh_resp += 64'(32'(sh_run.start - sh_run.arrival));
                    sh_wait += 64'(turn) - 64'(sh_run.total);
                    sh_done++;
                    sh_run_on = 1'b0;
                    void'(pick_next(cand, 0, r.now));
                end
            end
            scd_pkg::OP_EXPIRE: begin
                if (!sh_run_on) begin
                    o.idle_error = 1'b1;
                end else begin
                    preempt_running(r.now);
                    sh_run.requeue = r.now;
                    cand[0]   = sh_run;
                    sh_run_on = 1'b0;
                    void'(pick_next(cand, 1, r.now));
                end
            end
            default: ;
        endcase
        o.core_busy      = sh_run_on;
        o.running_id     = sh_run_on ? sh_run.id : 16'd0;
        o.sum_turnaround = sh_turn;
        o.sum_response   = sh_resp;
        o.sum_wait       = sh_wait;
        o.jobs_done      = sh_done;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    logic [31:0] clock_now;   // event time stamped on random requests

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // valid stays high after an accept unless a gap or a policy change follows
    task automatic send_request(scd_tb_pkg::t_req r);
        int g;
        g = gap_len();
        if (g > 0) begin
            job_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        job_ch.valid      <= 1'b1;
        job_ch.op         <= r.op;
        job_ch.job_id     <= r.job_id;
        job_ch.now        <= r.now;
        job_ch.run_length <= r.run_length;
        job_ch.prio       <= r.prio;
        do @(posedge i_clk); while (!job_ch.ready);
        expected_results.push_back(schedule_event(r));
        accepted_reqs++;
    endtask

    task automatic set_policy(logic [2:0] p);
        // block must be quiet: all results in, plus a full dispatch pass
        job_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.policy <= p;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sh_policy = p;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic scd_tb_pkg::t_req mk(scd_pkg::t_op op, logic [15:0] id,
                                            logic [31:0] now, logic [31:0] len,
                                            logic [15:0] pr);
        scd_tb_pkg::t_req r;
        r.op = op; r.job_id = id; r.now = now; r.run_length = len; r.prio = pr;
        return r;
    endfunction

    // random request with mostly sane content; job ids drawn from the full 16-bit range
    function automatic scd_tb_pkg::t_req rand_request(ref logic [15:0] last_id);
        scd_tb_pkg::t_req r;
        int   p;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) clock_now += $urandom_range(0, 100000);
        else                           clock_now += $urandom_range(0, 3);
        r.now        = clock_now;
        r.prio       = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        r.run_length = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
        r.job_id     = 16'($urandom);
        if (p < 48)      r.op = scd_pkg::OP_ARRIVE;
        else if (p < 76) r.op = scd_pkg::OP_FINISH;
        else if (p < 97) r.op = scd_pkg::OP_EXPIRE;
        else             r.op = scd_pkg::OP_NONE;
        // most finishes name the running job
        if (r.op == scd_pkg::OP_FINISH && sh_run_on && $urandom_range(0, 9) != 0)
            r.job_id = sh_run.id;
        last_id = r.job_id;
        return r;
    endfunction

    // directed rows: expectation typed in only for the obvious cases
    typedef struct {
        scd_tb_pkg::t_req r;
        bit               typed;
        scd_tb_pkg::t_res x;
    } t_row;

    initial begin
        t_row             rows [$];
        scd_tb_pkg::t_res z;
        logic [15:0]      lid;
        logic [2:0]       plist [8];

        errors = 0; accepted_reqs = 0; accepted_results = 0; drv_done = 0;
        job_ch.valid <= 1'b0; job_ch.op <= scd_pkg::OP_NONE; job_ch.job_id <= '0;
        job_ch.now <= '0; job_ch.run_length <= '0; job_ch.prio <= '0;
        cfg_ch.valid <= 1'b0; cfg_ch.policy <= scd_pkg::POL_FCFS;
        i_rst_n <= 1'b0;

        sh_policy = scd_pkg::POL_FCFS; sh_insert = 0; sh_run_on = 0; sh_run = '0;
        sh_slice = 0;
        sh_turn = 0; sh_resp = 0; sh_wait = 0; sh_done = 0;
        for (int i = 0; i < scd_pkg::QUEUE_DEPTH; i++) begin
            sh_valid[i] = 0; sh_slot[i] = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: idle errors, unknown op, all typed
        z = '{default: '0};
        z.idle_error = 1;
        rows.push_back('{mk(scd_pkg::OP_FINISH, 16'hFFFF, 0, 0, 0), 1, z});
        rows.push_back('{mk(scd_pkg::OP_EXPIRE, 0, 0, 0, 0), 1, z});
        z.idle_error = 0;
        rows.push_back('{mk(scd_pkg::OP_NONE, 16'hFFFF, '1, '1, '1), 1, z});
        // arrival on idle core runs at once
        z.core_busy = 1; z.running_id = 16'hFFFF; z.arrival_dispatched = 1;
        rows.push_back('{mk(scd_pkg::OP_ARRIVE, 16'hFFFF, 0, 32'hFFFF_FFFF, 16'hFFFF), 1, z});
        // fill the queue, then overflow (typed: dropped arrival)
        for (int i = 0; i < scd_pkg::QUEUE_DEPTH; i++)
            rows.push_back('{mk(scd_pkg::OP_ARRIVE, 16'(i + 1), 1, 32'(i), 16'(i)), 0, z});
        z.arrival_dispatched = 0; z.queue_full = 1;
        rows.push_back('{mk(scd_pkg::OP_ARRIVE, 16'h1234, 1, 5, 0), 1, z});
        // expiry in same time unit, wrong job finish, extreme time
        rows.push_back('{mk(scd_pkg::OP_EXPIRE, 0, 1, 0, 0), 0, z});
        rows.push_back('{mk(scd_pkg::OP_FINISH, 16'h0000, 2, 0, 0), 0, z});
        rows.push_back('{mk(scd_pkg::OP_FINISH, 16'h0001, 32'hFFFF_FFFF, 0, 0), 0, z});

        foreach (rows[i]) begin
            send_request(rows[i].r);
            if (rows[i].typed) begin
                // replaces the shadow expectation; typed values must agree with the shadow model too
                expected_results[$] = rows[i].x;
            end
        end
        clock_now = 32'hFFFF_FFFF;

        // random phases: each policy in turn, codes 6 and 7 included
        plist = '{scd_pkg::POL_PRIO, scd_pkg::POL_PPRIO, scd_pkg::POL_SRTF, scd_pkg::POL_RR,
                  scd_pkg::POL_SJF, 3'd6, 3'd7, scd_pkg::POL_FCFS};
        for (int ph = 0; ph < 8; ph++) begin
            set_policy(plist[ph]);
            clock_now = (ph % 2) ? 32'hFFFF_0000 : $urandom_range(0, 1000);
            for (int n = 0; n < 215; n++) begin
                if (clock_now > 32'hFFF0_0000 && (ph % 2) == 0) clock_now = 0;
                send_request(rand_request(lid));
            end
        end
        job_ch.valid <= 1'b0;
        drv_done = 1;
    end

    // ---------------------------------------------------------------
    // Result side: random back-pressure, field-by-field check
    // ---------------------------------------------------------------
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            res_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
            @(posedge i_clk);
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        scd_tb_pkg::t_res x;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            accepted_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end else begin
                x = expected_results.pop_front();
                check_field("core_busy", x.core_busy, res_ch.core_busy);
                check_field("running_id", x.running_id, res_ch.running_id);
                check_field("arrival_dispatched", x.arrival_dispatched,
                            res_ch.arrival_dispatched);
                check_field("wrong_job", x.wrong_job, res_ch.wrong_job);
                check_field("idle_error", x.idle_error, res_ch.idle_error);
                check_field("queue_full", x.queue_full, res_ch.queue_full);
                check_field("sum_turnaround", x.sum_turnaround, res_ch.sum_turnaround);
                check_field("sum_response", x.sum_response, res_ch.sum_response);
                check_field("sum_wait", x.sum_wait, res_ch.sum_wait);
                check_field("jobs_done", x.jobs_done, res_ch.jobs_done);
            end
        end
    end

    // watchdog and end of run
    initial begin
        int idle_cycles;
        int last_sum;
        idle_cycles = 0;
        last_sum = 0;
        forever begin
            @(posedge i_clk);
            if (accepted_reqs + accepted_results != last_sum) begin
                last_sum = accepted_reqs + accepted_results;
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
            if (drv_done && expected_results.size() == 0) begin
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                if (errors == 0 && expected_results.size() == 0) begin
                    $display("Regression PASS");
                end else begin
                    $display("Regression FAIL");
                end
                $finish;
            end
        end
    end

endmodule

/* sim.f */
rtl/core/scd_pkg.sv
rtl/core/scd_if.sv
rtl/core/scd_datapath.sv
rtl/core/scd_ctrl.sv
rtl/core/single_core_job_scheduler_top.sv
dv/scd_tb_if.sv
dv/testbench.sv
